// ===== hw/rtl/samr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// samr_pkg: shared types and constants for the append / remove-max sequence
// Store depth, derived widths, status codes, controller states and the
// control bundle that drives the row of storage cells.
// ---------------------------------------------------------------------------
package samr_pkg;

    localparam int DEPTH     = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 7;

    typedef enum logic [0:0] {
        CMD_APPEND     = 1'b0,
        CMD_REMOVE_MAX = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_SKIP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } t_state;

    // Control bundle for the cell row: shift every cell toward the head and
    // load one cell, picked by position, with the given data.
    typedef struct packed {
        logic                     shift;
        logic                     load;
        logic [CNT_W-1:0]         wpos;
        logic signed [DATA_W-1:0] data;
    } t_chain_ctl;

endpackage

// ===== hw/rtl/samr_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// samr_cell: one storage cell of the sequence row
// Holds one entry; takes the neighbor's value on a shift, or fresh data on
// a load, which wins over the shift.
// ---------------------------------------------------------------------------
module samr_cell import samr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  logic                     i_load,
    input  logic signed [DATA_W-1:0] i_load_data,
    input  logic signed [DATA_W-1:0] i_next,
    output logic signed [DATA_W-1:0] o_value
);

    logic signed [DATA_W-1:0] r_value;

    // Load new data, otherwise take the tail-side neighbor on a shift
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_load_data;
        end else if (i_shift) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;

endmodule

// ===== hw/rtl/samr_chain.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// samr_chain: row of DEPTH storage cells
// Position 0 is the head. On a shift every cell takes its tail-side
// neighbor; the cell whose position matches the write position loads.
// ---------------------------------------------------------------------------
module samr_chain import samr_pkg::*; (
    input  logic                     i_clk,
    input  t_chain_ctl               i_ctl,
    output logic signed [DATA_W-1:0] o_head
);

    logic signed [DATA_W-1:0] w_val [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic signed [DATA_W-1:0] w_next;
            logic                     w_load;

            // Feed from the tail-side neighbor; the last cell keeps its own value
            if (k == DEPTH - 1) begin : g_last
                assign w_next = w_val[k];
            end else begin : g_mid
                assign w_next = w_val[k+1];
            end

            assign w_load = i_ctl.load && (i_ctl.wpos == CNT_W'(k));

            samr_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (i_ctl.shift),
                .i_load      (w_load),
                .i_load_data (i_ctl.data),
                .i_next      (w_next),
                .o_value     (w_val[k])
            );
        end
    endgenerate

    assign o_head = w_val[0];

endmodule

// ===== hw/rtl/sequence_append_remove_max.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sequence_append_remove_max: ordered signed sequence with remove-max
// Input beats carry a command and a value; each beat yields one result beat
// with entry count, removed count, maximum found and status.
//
// Usage:
//   - Input channel i_valid / o_ready; output channel o_valid / i_ready.
//   - Append: the value lands at the tail in the accept cycle. A full store
//     drops the value (status 1).
//   - Remove-max with N >= 2 entries: one pass rotates the row of cells past
//     the head to find the maximum, a second pass rotates again and drops
//     every entry equal to it. The row of cells moves one entry past the head
//     per cycle in each pass, and the result then goes through the done state
//     to the output register.
//   - Remove-max with fewer than two entries: status 2, no rotation.
//   - A new beat is taken as soon as the controller is back in idle, even
//     while the previous result still waits in the output register. When the
//     receiver stalls, the next result holds until that register drains.
//   - Reset empties the sequence and clears the output valid flag; the cells
//     keep their contents, which are never read before being written.
// ---------------------------------------------------------------------------
module sequence_append_remove_max import samr_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic signed [DATA_W-1:0]    i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [OUT_CNT_W-1:0]        o_entry_count,
    output logic [OUT_CNT_W-1:0]        o_removed_count,
    output logic signed [DATA_W-1:0]    o_max_found,
    output logic [1:0]                  o_status
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_step, n_step;
    logic [CNT_W-1:0]         r_wpos, n_wpos;
    logic [CNT_W-1:0]         r_removed, n_removed;
    logic signed [DATA_W-1:0] r_max, n_max;
    t_status                  r_stat, n_stat;

    logic                     r_out_valid, n_out_valid;
    logic [OUT_CNT_W-1:0]     r_out_count, n_out_count;
    logic [OUT_CNT_W-1:0]     r_out_removed, n_out_removed;
    logic signed [DATA_W-1:0] r_out_max, n_out_max;
    logic [1:0]               r_out_stat, n_out_stat;

    t_chain_ctl               w_ctl;
    logic signed [DATA_W-1:0] w_head;
    logic                     w_accept;
    logic                     w_last;
    logic                     w_out_free;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_last     = (r_step == r_count - CNT_W'(1));
    assign w_out_free = !r_out_valid || i_ready;

    samr_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    // State and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_step        <= n_step;
        r_wpos        <= n_wpos;
        r_removed     <= n_removed;
        r_max         <= n_max;
        r_stat        <= n_stat;
        r_out_count   <= n_out_count;
        r_out_removed <= n_out_removed;
        r_out_max     <= n_out_max;
        r_out_stat    <= n_out_stat;
    end

    // Next state, cell row control and result capture
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_wpos        = r_wpos;
        n_removed     = r_removed;
        n_max         = r_max;
        n_stat        = r_stat;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_count   = r_out_count;
        n_out_removed = r_out_removed;
        n_out_max     = r_out_max;
        n_out_stat    = r_out_stat;
        w_ctl.shift   = 1'b0;
        w_ctl.load    = 1'b0;
        w_ctl.wpos    = r_wpos;
        w_ctl.data    = w_head;

        case (r_state)
            S_IDLE: begin
                w_ctl.wpos = r_count;
                w_ctl.data = i_value;
                if (w_accept) begin
                    n_removed = '0;
                    n_max     = '0;
                    n_stat    = STAT_DONE;
                    n_state   = S_DONE;
                    if (t_cmd'(i_cmd) == CMD_APPEND) begin
                        // Append at the tail, or drop when full
                        if (r_count < CNT_W'(DEPTH)) begin
                            w_ctl.load = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end else begin
                            n_stat = STAT_FULL;
                        end
                    end else if (r_count < CNT_W'(2)) begin
                        n_stat = STAT_SKIP;
                    end else begin
                        n_step  = '0;
                        n_wpos  = r_count - CNT_W'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Rotate the held entries once, tracking the largest head value
                w_ctl.shift = 1'b1;
                w_ctl.load  = 1'b1;
                if (r_step == '0 || w_head > r_max) begin
                    n_max = w_head;
                end
                n_step = r_step + CNT_W'(1);
                if (w_last) begin
                    n_step  = '0;
                    n_wpos  = r_count - CNT_W'(1);
                    n_state = S_COMPACT;
                end
            end
            S_COMPACT: begin
                // Rotate again; keep non-max entries, drop the max ones
                w_ctl.shift = 1'b1;
                if (w_head != r_max) begin
                    w_ctl.load = 1'b1;
                end else begin
                    n_removed = r_removed + CNT_W'(1);
                    n_wpos    = r_wpos - CNT_W'(1);
                end
                n_step = r_step + CNT_W'(1);
                if (w_last) begin
                    n_count = r_count - n_removed;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_count   = OUT_CNT_W'(r_count);
                    n_out_removed = OUT_CNT_W'(r_removed);
                    n_out_max     = r_max;
                    n_out_stat    = r_stat;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_entry_count   = r_out_count;
    assign o_removed_count = r_out_removed;
    assign o_max_found     = r_out_max;
    assign o_status        = r_out_stat;

    // The fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above store depth");

    // Compaction never grows the sequence
    a_compact_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPACT |=> r_count <= $past(r_count))
        else $error("fill count grew during compaction");

    // A result reporting removals always carries a done status
    a_removed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed_count != '0 |-> o_status == STAT_DONE)
        else $error("removed entries reported with non-done status");

endmodule
